FILE: src/lpe_pkg.sv
// Shared types and constants of the lexicographic permutation engine.
`timescale 1ns / 1ps

package lpe_pkg;

  localparam int ElemW       = 8;
  localparam int PosW        = 4;
  localparam int OpW         = 2;
  localparam int PosLimit    = 16;
  localparam int DefCapacity = 16;
  localparam int OutDataW    = 16;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_START   = 2'd2,
    OP_ADVANCE = 2'd3
  } lpe_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIVOT,
    ST_SORT,
    ST_SWAP,
    ST_EMIT,
    ST_FIN
  } lpe_state_e;

  typedef enum logic [2:0] {
    MD_HOLD,
    MD_APPEND,
    MD_MARK_ALL,
    MD_MARK_SUF,
    MD_SORT,
    MD_SWAP,
    MD_ROTATE
  } lpe_mode_e;

  typedef struct packed {
    lpe_mode_e               mode;
    logic                    phase_odd;
    logic signed [ElemW-1:0] pivot;
    logic signed [ElemW-1:0] value;
  } lpe_ctl_t;

  typedef struct packed {
    logic live;
    logic left_live;
    logic sel;
    logic tail;
    logic odd;
  } lpe_pos_t;

  typedef struct packed {
    logic signed [ElemW-1:0] elem;
    logic                    sfx;
    logic                    chain;
    logic                    piv;
    logic                    tgt;
  } lpe_cell_st_t;

endpackage

FILE: src/lpe_cell.sv
// One cell of the element row: holds an element and its suffix flag.
`timescale 1ns / 1ps

module lpe_cell import lpe_pkg::*; (
  input  logic                    clk_i,
  input  lpe_ctl_t                ctl_i,
  input  lpe_pos_t                pos_i,
  input  lpe_cell_st_t            left_i,
  input  lpe_cell_st_t            right_i,
  input  logic signed [ElemW-1:0] first_i,
  input  logic signed [ElemW-1:0] swap_i,
  output lpe_cell_st_t            st_o
);

  logic signed [ElemW-1:0] elem_q, elem_d;
  logic                    sfx_q, sfx_d;
  logic                    rise, pair_r, pair_l, swap_r, swap_l, piv, tgt;

  assign rise   = pos_i.live && pos_i.left_live && (left_i.elem < elem_q);
  assign pair_r = (pos_i.odd == ctl_i.phase_odd) && sfx_q && right_i.sfx;
  assign pair_l = (pos_i.odd != ctl_i.phase_odd) && sfx_q && left_i.sfx;
  assign swap_r = pair_r && (elem_q > right_i.elem);
  assign swap_l = pair_l && (left_i.elem > elem_q);
  assign piv    = !sfx_q && right_i.sfx;
  assign tgt    = sfx_q && (elem_q > ctl_i.pivot) &&
                  !(left_i.sfx && (left_i.elem > ctl_i.pivot));

  always_comb begin
    elem_d = elem_q;
    sfx_d  = sfx_q;
    case (ctl_i.mode)
      MD_APPEND: begin
        if (pos_i.sel) begin
          elem_d = ctl_i.value;
        end
      end
      MD_MARK_ALL: begin
        sfx_d = pos_i.live;
      end
      MD_MARK_SUF: begin
        sfx_d = pos_i.live && !right_i.chain;
      end
      MD_SORT: begin
        if (swap_r) begin
          elem_d = right_i.elem;
        end else if (swap_l) begin
          elem_d = left_i.elem;
        end
      end
      MD_SWAP: begin
        if (piv) begin
          elem_d = swap_i;
        end else if (tgt) begin
          elem_d = ctl_i.pivot;
        end
      end
      MD_ROTATE: begin
        if (pos_i.live) begin
          elem_d = pos_i.tail ? first_i : right_i.elem;
        end
      end
      default: begin
        elem_d = elem_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
    sfx_q  <= sfx_d;
  end

  always_comb begin
    st_o.elem  = elem_q;
    st_o.sfx   = sfx_q;
    st_o.chain = rise | right_i.chain;
    st_o.piv   = piv;
    st_o.tgt   = tgt;
  end

endmodule

FILE: src/lexicographic_permutation_engine.sv
// Top level of the lexicographic permutation engine: control and the cell row.
//
//   channel   dir  tdata                   tuser             tlast
//   s_axis    in   [7:0] element_value     [1:0] operation   -
//   m_axis    out  [7:0] out_element,      [0] finished      last_of_run
//                  [11:8] out_position
//
// A start sorts the stored elements and an advance steps to the next arrangement, each
// followed by the unload of the row; an advance without a rise, or either on an empty
// store, yields only the finished word. The sort is an odd-even transposition sort
// over the cell row; the unload rotates the row, one word per cycle unless stalled.
// Reset clears the element count and the control; the store needs no clearing pass.
// The input is ready only between items; a stalled output freezes the unload.
`timescale 1ns / 1ps

module lexicographic_permutation_engine import lpe_pkg::*; #(
  parameter int CAPACITY = DefCapacity
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [ElemW-1:0]    s_axis_tdata,   // [7:0] element_value
  input  logic [OpW-1:0]      s_axis_tuser,   // [1:0] operation
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [7:0] out_element, [11:8] out_position
  output logic                m_axis_tlast,
  output logic                m_axis_tuser    // [0] finished
);

  localparam int EffCap = (CAPACITY < PosLimit) ? CAPACITY : PosLimit;
  localparam int CntW   = $clog2(EffCap + 1);
  localparam int IdxW   = $clog2(EffCap);

  lpe_state_e              state_q, state_d;
  logic [CntW-1:0]         count_q, count_d;
  logic [IdxW-1:0]         phase_q, phase_d;
  logic [IdxW-1:0]         pos_q, pos_d;
  logic                    adv_q, adv_d;
  logic signed [ElemW-1:0] pivot_q;

  logic                    out_valid_q;
  logic signed [ElemW-1:0] out_elem_q;
  logic [PosW-1:0]         out_pos_q;
  logic                    out_last_q;
  logic                    out_fin_q;

  lpe_ctl_t                ctl;
  lpe_op_e                 op;
  logic                    in_acc, out_free, out_load, out_fin, found, at_last;
  logic [CntW-1:0]         count_m1;
  logic [IdxW-1:0]         last_idx;
  logic signed [ElemW-1:0] pivot_val, swap_val;

  lpe_cell_st_t            cst [EffCap];
  lpe_cell_st_t            lft [EffCap];
  lpe_cell_st_t            rgt [EffCap];
  lpe_pos_t                pst [EffCap];
  logic [EffCap-1:0]       piv_vec, tgt_vec;

  assign op       = lpe_op_e'(s_axis_tuser);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign count_m1 = count_q - CntW'(1);
  assign last_idx = count_m1[IdxW-1:0];
  assign at_last  = (pos_q == last_idx);
  assign found    = cst[0].chain;

  for (genvar k = 0; k < EffCap; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign lft[k] = '0;
    end else begin : g_mid_l
      assign lft[k] = cst[k-1];
    end
    if (k == EffCap - 1) begin : g_last
      assign rgt[k] = '0;
    end else begin : g_mid_r
      assign rgt[k] = cst[k+1];
    end

    assign pst[k].live      = (CntW'(k) < count_q);
    assign pst[k].left_live = (k != 0);
    assign pst[k].sel       = (CntW'(k) == count_q);
    assign pst[k].tail      = (CntW'(k) == count_m1);
    assign pst[k].odd       = (k % 2 == 1);
    assign piv_vec[k]       = cst[k].piv;
    assign tgt_vec[k]       = cst[k].tgt;

    lpe_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .pos_i   (pst[k]),
      .left_i  (lft[k]),
      .right_i (rgt[k]),
      .first_i (cst[0].elem),
      .swap_i  (swap_val),
      .st_o    (cst[k])
    );
  end

  always_comb begin
    pivot_val = '0;
    swap_val  = '0;
    for (int k = 0; k < EffCap; k++) begin
      pivot_val = pivot_val | (cst[k].piv ? cst[k].elem : '0);
      swap_val  = swap_val  | (cst[k].tgt ? cst[k].elem : '0);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (op == OP_START || op == OP_ADVANCE)) begin
          if (count_q == '0) begin
            state_d = ST_FIN;
          end else if (op == OP_START) begin
            state_d = ST_SORT;
          end else if (found) begin
            state_d = ST_PIVOT;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_PIVOT: begin
        state_d = ST_SORT;
      end
      ST_SORT: begin
        if (phase_q == last_idx) begin
          state_d = adv_q ? ST_SWAP : ST_EMIT;
        end
      end
      ST_SWAP: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free && at_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    ctl.mode      = MD_HOLD;
    ctl.phase_odd = phase_q[0];
    ctl.pivot     = pivot_q;
    ctl.value     = s_axis_tdata;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    out_fin       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          case (op)
            OP_APPEND:  ctl.mode = MD_APPEND;
            OP_START:   ctl.mode = MD_MARK_ALL;
            OP_ADVANCE: ctl.mode = MD_MARK_SUF;
            default:    ctl.mode = MD_HOLD;
          endcase
        end
      end
      ST_SORT: begin
        ctl.mode = MD_SORT;
      end
      ST_SWAP: begin
        ctl.mode = MD_SWAP;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          ctl.mode = MD_ROTATE;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          out_fin  = 1'b1;
        end
      end
      default: begin
        ctl.mode = MD_HOLD;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    phase_d = phase_q;
    pos_d   = pos_q;
    adv_d   = adv_q;
    if (in_acc) begin
      phase_d = '0;
      pos_d   = '0;
      adv_d   = (op == OP_ADVANCE);
      if (op == OP_CLEAR) begin
        count_d = '0;
      end else if (op == OP_APPEND && count_q < CntW'(EffCap)) begin
        count_d = count_q + CntW'(1);
      end
    end
    if (state_q == ST_SORT) begin
      phase_d = phase_q + IdxW'(1);
    end
    if (state_q == ST_EMIT && out_load) begin
      pos_d = pos_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      phase_q <= '0;
      pos_q   <= '0;
      adv_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      phase_q <= phase_d;
      pos_q   <= pos_d;
      adv_q   <= adv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_PIVOT) begin
      pivot_q <= pivot_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_elem_q <= out_fin ? '0 : cst[0].elem;
      out_pos_q  <= out_fin ? '0 : PosW'(pos_q);
      out_last_q <= out_fin ? 1'b1 : at_last;
      out_fin_q  <= out_fin;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - ElemW - PosW){1'b0}}, out_pos_q, out_elem_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_fin_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(EffCap))
    else $error("element count beyond capacity");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !out_load)
    else $error("pending output word overwritten");

  a_swap_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWAP) |-> ($onehot(piv_vec) && $onehot(tgt_vec)))
    else $error("swap without a single pivot and target");

  a_fin_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("finished word not marked last");

  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (count_q != '0))
    else $error("unload of an empty row");
`endif

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the lexicographic permutation engine.
`timescale 1ns / 1ps

module tb;
  import lpe_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 235;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_SHOWN    = 20;

  typedef struct packed {
    logic signed [ElemW-1:0] elem;
    logic [PosW-1:0]         pos;
    logic                    last;
    logic                    fin;
  } perm_word_t;

  typedef struct packed {
    lpe_op_e    op;
    logic [7:0] val;
    logic       typed;
    perm_word_t want;
  } stim_row_t;

  localparam perm_word_t FIN_WORD = '{elem: 8'sd0, pos: 4'd0, last: 1'b1, fin: 1'b1};
  localparam perm_word_t NO_WORD  = '0;
  localparam perm_word_t TOP_WORD = '{elem: 8'sd127, pos: 4'd0, last: 1'b1, fin: 1'b0};

  localparam int PLAN_LEN = 25;
  localparam stim_row_t PLAN [PLAN_LEN] = '{
    '{OP_START,   8'h00, 1'b1, FIN_WORD},
    '{OP_ADVANCE, 8'hff, 1'b1, FIN_WORD},
    '{OP_APPEND,  8'h7f, 1'b0, NO_WORD},
    '{OP_START,   8'h00, 1'b1, TOP_WORD},
    '{OP_ADVANCE, 8'h00, 1'b1, FIN_WORD},
    '{OP_CLEAR,   8'h00, 1'b0, NO_WORD},
    '{OP_APPEND,  8'h80, 1'b0, NO_WORD},
    '{OP_APPEND,  8'h7f, 1'b0, NO_WORD},
    '{OP_APPEND,  8'h80, 1'b0, NO_WORD},
    '{OP_APPEND,  8'h00, 1'b0, NO_WORD},
    '{OP_START,   8'h00, 1'b0, NO_WORD},
    '{OP_ADVANCE, 8'h00, 1'b0, NO_WORD},
    '{OP_ADVANCE, 8'h00, 1'b0, NO_WORD},
    '{OP_CLEAR,   8'hff, 1'b0, NO_WORD},
    '{OP_APPEND,  8'h55, 1'b0, NO_WORD},
    '{OP_APPEND,  8'haa, 1'b0, NO_WORD},
    '{OP_ADVANCE, 8'h00, 1'b1, FIN_WORD},
    '{OP_START,   8'haa, 1'b0, NO_WORD},
    '{OP_ADVANCE, 8'h55, 1'b0, NO_WORD},
    '{OP_ADVANCE, 8'h00, 1'b1, FIN_WORD},
    '{OP_CLEAR,   8'h00, 1'b0, NO_WORD},
    '{OP_APPEND,  8'h09, 1'b0, NO_WORD},
    '{OP_APPEND,  8'h09, 1'b0, NO_WORD},
    '{OP_START,   8'h00, 1'b0, NO_WORD},
    '{OP_ADVANCE, 8'h00, 1'b1, FIN_WORD}
  };

  logic                clk_i;
  logic                rst_ni   = 1'b0;
  logic                s_tvalid = 1'b0;
  logic [ElemW-1:0]    s_tdata  = '0;
  logic [OpW-1:0]      s_tuser  = OP_CLEAR;
  logic                s_tready;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tlast;
  logic                m_tuser;

  lexicographic_permutation_engine dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tlast (m_tlast),
    .m_axis_tuser (m_tuser)
  );

  logic signed [ElemW-1:0] arrangement [PosLimit];
  int unsigned             stored_n;
  perm_word_t              fresh_words [$];
  perm_word_t              pending_words [$];

  int  errors;
  int  cycles;
  int  items_sent;
  int  starts_sent;
  int  advances_sent;
  int  appends_dropped;
  int  words_seen;
  int  finished_seen;
  int  stall_left;
  bit  no_idle;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d words outstanding.", cycles,
               pending_words.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    if (errors <= MAX_SHOWN)
      $display("%0t: %s mismatch, got %0d, expected %0d", $realtime, what, got, want);
  endtask

  function automatic void sort_from(int unsigned lo);
    logic signed [ElemW-1:0] key;
    int unsigned             j;
    for (int unsigned i = lo + 1; i < stored_n; i++) begin
      key = arrangement[i];
      j = i;
      while (j > lo && arrangement[j-1] > key) begin
        arrangement[j] = arrangement[j-1];
        j--;
      end
      arrangement[j] = key;
    end
  endfunction

  // Start sorts the store, advance finds the next lexicographic one; fills fresh_words.
  function automatic void predict_permutation(lpe_op_e op, logic signed [ElemW-1:0] v);
    int unsigned             rise;
    int unsigned             succ;
    bit                      found;
    logic signed [ElemW-1:0] held;
    perm_word_t              w;
    fresh_words.delete();
    case (op)
      OP_CLEAR: stored_n = 0;
      OP_APPEND: begin
        if (stored_n < PosLimit) begin
          arrangement[stored_n] = v;
          stored_n++;
        end else begin
          appends_dropped++;
        end
      end
      default: begin
        found = 1'b0;
        if (stored_n != 0 && op == OP_START) begin
          sort_from(0);
          found = 1'b1;
        end else if (stored_n != 0) begin
          for (int unsigned k = stored_n - 1; k > 0 && !found; k--) begin
            if (arrangement[k-1] < arrangement[k]) begin
              rise  = k - 1;
              found = 1'b1;
            end
          end
          if (found) begin
            succ = rise + 1;
            for (int unsigned k = rise + 2; k < stored_n; k++)
              if (arrangement[k] > arrangement[rise] && arrangement[k] < arrangement[succ])
                succ = k;
            held              = arrangement[rise];
            arrangement[rise] = arrangement[succ];
            arrangement[succ] = held;
            sort_from(rise + 1);
          end
        end
        if (!found) begin
          fresh_words.push_back(FIN_WORD);
        end else begin
          for (int unsigned k = 0; k < stored_n; k++) begin
            w.elem = arrangement[k];
            w.pos  = k[PosW-1:0];
            w.last = (k + 1 == stored_n);
            w.fin  = 1'b0;
            fresh_words.push_back(w);
          end
        end
      end
    endcase
  endfunction

  task automatic send_word(lpe_op_e op, logic [7:0] val, bit typed, perm_word_t want);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= val;
    s_tuser  <= op;
    do @(posedge clk_i); while (!s_tready);
    predict_permutation(op, val);
    if (typed)
      pending_words.push_back(want);
    else
      foreach (fresh_words[k]) pending_words.push_back(fresh_words[k]);
    items_sent++;
    if (op == OP_START) starts_sent++;
    if (op == OP_ADVANCE) advances_sent++;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (pending_words.size() != 0);
  endtask

  always @(posedge clk_i) begin
    perm_word_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      words_seen++;
      if (m_tuser) finished_seen++;
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word, element", $signed(m_tdata[7:0]), 0);
      end else begin
        want = pending_words.pop_front();
        if (m_tdata[7:0] !== want.elem)
          report_mismatch("element", $signed(m_tdata[7:0]), want.elem);
        if (m_tdata[11:8] !== want.pos)
          report_mismatch("position", m_tdata[11:8], want.pos);
        if (m_tdata[15:12] !== 4'd0)
          report_mismatch("tdata padding", m_tdata[15:12], 0);
        if (m_tlast !== want.last)
          report_mismatch("last_of_run", m_tlast, want.last);
        if (m_tuser !== want.fin)
          report_mismatch("finished", m_tuser, want.fin);
      end
      stall_left = no_idle ? 0 : $urandom_range(0, 5);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    m_tready <= rst_ni && (stall_left == 0);
  end

  initial begin
    int         pick;
    int         n;
    int         steps;
    bit         narrow;
    logic [7:0] v;
    stored_n = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < PLAN_LEN; r++)
      send_word(PLAN[r].op, PLAN[r].val, PLAN[r].typed, PLAN[r].want);
    s_tvalid <= 1'b0;
    wait_drained();

    while (items_sent < PLAN_LEN + RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 4))
          send_word(lpe_op_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0,
                    NO_WORD);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 4)       n = 0;
        else if (pick < 60) n = $urandom_range(1, 4);
        else if (pick < 85) n = $urandom_range(5, 8);
        else if (pick < 95) n = $urandom_range(9, 16);
        else                n = $urandom_range(17, 19);
        narrow = $urandom_range(0, 1);
        send_word(OP_CLEAR, 8'($urandom_range(0, 255)), 1'b0, NO_WORD);
        for (int k = 0; k < n; k++) begin
          v = narrow ? 8'($urandom_range(0, 4) + 254) : 8'($urandom_range(0, 255));
          send_word(OP_APPEND, v, 1'b0, NO_WORD);
        end
        if ($urandom_range(0, 4) != 0)
          send_word(OP_START, 8'($urandom_range(0, 255)), 1'b0, NO_WORD);
        steps = $urandom_range(1, (n <= 4) ? 30 : 8);
        repeat (steps)
          send_word(OP_ADVANCE, 8'($urandom_range(0, 255)), 1'b0, NO_WORD);
      end
      if ($urandom_range(0, 5) == 0) begin
        s_tvalid <= 1'b0;
        wait_drained();
      end
    end
    s_tvalid <= 1'b0;
    no_idle = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d words: %0d starts, %0d advances, %0d appends past a full store.",
             items_sent, starts_sent, advances_sent, appends_dropped);
    $display("Received %0d arrangement words, %0d of them end-of-sequence markers.",
             words_seen, finished_seen);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches.", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
src/lpe_pkg.sv
src/lpe_cell.sv
src/lexicographic_permutation_engine.sv
tb/tb.sv
